>>> src/even_odd_partition_sorter_unit_macros.svh
// Assertion macros shared by the checker.
// Both expect clk and arst_n in scope.
`ifndef EVEN_ODD_PARTITION_SORTER_UNIT_MACROS_SVH
`define EVEN_ODD_PARTITION_SORTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define EOPS_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("label failed");

// Next-cycle implication.
`define EOPS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("label failed");

`endif

>>> src/eops_pkg.sv
`timescale 1ns / 1ps
package eops_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS);

	typedef struct packed {
		logic              valid;
		logic              lt;
		logic [DATA_W-1:0] value;
	} cell_t;

	// Order key: evens ascending, then odds descending.
	function automatic logic [DATA_W:0] key_f(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] u;
		u = {~v[DATA_W-1], v[DATA_W-2:0]};
		key_f = v[0] ? {1'b1, ~u} : {1'b0, u};
	endfunction

	function automatic logic before_f(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		before_f = key_f(a) < key_f(b);
	endfunction

endpackage

>>> src/even_odd_partition_sorter_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                     tuser  tlast
// s_*      in   [31:0] value (signed)     -      final_item
// m_*      out  [31:0] sorted_value (sgn) -      end_of_batch
//
// Load: one beat per cycle, each value inserted in order into a chain of
// MAX_ITEMS cells. Drain: after the last beat (or a full chain) the chain
// shifts toward cell 0, one result per cycle while the output is not stalled.
// s_tready is low while draining. Reset clears all valid bits and the count.
// A stall on m_tready holds the output register and freezes the chain.
module even_odd_partition_sorter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast
);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                         state_q;
	logic [eops_pkg::CNT_W-1:0]   cnt_q;
	logic                         m_valid_q;
	logic [eops_pkg::DATA_W-1:0]  m_data_q;
	logic                         m_last_q;

	eops_pkg::cell_t              cells [eops_pkg::MAX_ITEMS];

	logic ins;
	logic pop;
	logic batch_end;
	logic chain_last;

	assign s_tready  = (state_q == ST_LOAD);
	assign ins       = s_tvalid && s_tready;
	// Treat the item that fills the chain as the last of the batch.
	assign batch_end = s_tlast || (cnt_q == eops_pkg::CNT_W'(eops_pkg::MAX_ITEMS - 1));
	// Advance the chain only when the output register is free or being taken.
	assign pop       = (state_q == ST_DRAIN) && cells[0].valid && (!m_valid_q || m_tready);
	// Cell 0 holds the final result when cell 1 is already empty.
	assign chain_last = !cells[1].valid;

	genvar gi;
	generate
		for (gi = 0; gi < eops_pkg::MAX_ITEMS; gi++) begin : g_cell
			eops_pkg::cell_t prev_c;
			eops_pkg::cell_t next_c;
			if (gi == 0) begin : g_first
				assign prev_c = '0;
			end else begin : g_mid
				assign prev_c = cells[gi-1];
			end
			if (gi == eops_pkg::MAX_ITEMS - 1) begin : g_tail
				assign next_c = '0;
			end else begin : g_body
				assign next_c = cells[gi+1];
			end
			eops_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.x      (s_tdata),
				.ins    (ins),
				.pop    (pop),
				.prev   (prev_c),
				.next   (next_c),
				.self   (cells[gi])
			);
		end
	endgenerate

	// Batch control: count loaded beats, switch to drain on the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (ins) begin
						if (batch_end) begin
							state_q <= ST_DRAIN;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + eops_pkg::CNT_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (pop && chain_last) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output register: hold on stall, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_data_q <= cells[0].value;
			m_last_q <= chain_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

>>> src/eops_cell.sv
`timescale 1ns / 1ps
module eops_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [eops_pkg::DATA_W-1:0]   x,
	input  logic                          ins,
	input  logic                          pop,
	input  eops_pkg::cell_t               prev,
	input  eops_pkg::cell_t               next,
	output eops_pkg::cell_t               self
);

	logic                        valid_q;
	logic [eops_pkg::DATA_W-1:0] value_q;
	logic                        lt;

	// New item belongs at or before this slot; empty slots always assert lt.
	assign lt = !valid_q || eops_pkg::before_f(x, value_q);

	assign self.valid = valid_q;
	assign self.lt    = lt;
	assign self.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= next.valid;
		end else if (ins) begin
			if (prev.lt) begin
				valid_q <= prev.valid;
			end else if (lt) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= next.value;
		end else if (ins) begin
			if (prev.lt) begin
				value_q <= prev.value;
			end else if (lt) begin
				value_q <= x;
			end
		end
	end

endmodule

>>> src/eops_checker.sv
`timescale 1ns / 1ps
`include "even_odd_partition_sorter_unit_macros.svh"
module eops_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	logic s_beat;
	assign s_beat = s_tvalid && s_tready;

	`EOPS_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// No loading right after the closing input beat: the batch drains first.
	`EOPS_ASSERT_NEXT(a_drain_after_last, s_beat && s_tlast, !s_tready)
	// While a non-final result waits, the rest of the batch is still inside.
	`EOPS_ASSERT_NOW(a_no_load_mid_batch, m_tvalid && !m_tlast, !s_tready)

endmodule

bind even_odd_partition_sorter_unit eops_checker u_eops_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
